// ===== hw/rtl/hse_pkg.sv =====
package hse_pkg;

   // Function codes carried on the request channel.
   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_FETCH = 1'b1;

   // Status reported by the sort sequencer to the front end.
   typedef struct packed {
      logic busy;
      logic done;
   } sort_stat_type;

endpackage

// ===== hw/rtl/hse_if.sv =====
interface hse_req_if #(
   parameter int DATA_WIDTH = 32
) ();
   logic                         valid;
   logic                         ready;
   logic                         func;
   logic signed [DATA_WIDTH-1:0] value;
   logic                         last;

   modport source (output valid, func, value, last, input ready);
   modport sink   (input valid, func, value, last, output ready);
endinterface

interface hse_rsp_if #(
   parameter int DATA_WIDTH = 32
) ();
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] sorted_value;
   logic                         final_res;
   logic                         empty_res;

   modport source (output valid, sorted_value, final_res, empty_res, input ready);
   modport sink   (input valid, sorted_value, final_res, empty_res, output ready);
endinterface

// ===== hw/rtl/hse_mem.sv =====
module hse_mem #(
   parameter int DEPTH      = 1024,
   parameter int DATA_WIDTH = 32,
   parameter int AW         = 10
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [AW-1:0]         wr_addr,
   input  logic [DATA_WIDTH-1:0] wr_data,
   input  logic [AW-1:0]         rd_addr,
   output logic [DATA_WIDTH-1:0] rd_data
);

   logic [DATA_WIDTH-1:0] mem [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/hse_sorter.sv =====
module hse_sorter #(
   parameter int DATA_WIDTH = 32,
   parameter int AW         = 10,
   parameter int CW         = 11
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic [CW-1:0]            count,
   output hse_pkg::sort_stat_type   stat,
   output logic                     wr_en,
   output logic [AW-1:0]            wr_addr,
   output logic [DATA_WIDTH-1:0]    wr_data,
   output logic [AW-1:0]            rd_addr,
   input  logic [DATA_WIDTH-1:0]    rd_data
);
   import hse_pkg::*;

   localparam int LW = AW + 2;

   typedef enum logic [3:0] {
      S_IDLE, S_BLD_RD, S_BLD_LD, S_CHK, S_RC, S_DEC, S_EX_R0, S_EX_RK, S_EX_WR
   } state_type;

   state_type             state_ff, state_in;
   logic                  extract_ff, extract_in;
   logic                  done_ff, done_in;
   logic [CW-1:0]         n_ff, n_in;
   logic [CW-1:0]         k_ff, k_in;
   logic [CW-1:0]         size_ff, size_in;
   logic [AW-1:0]         node_ff, node_in;
   logic [DATA_WIDTH-1:0] hold_ff, hold_in;
   logic [DATA_WIDTH-1:0] lv_ff, lv_in;

   logic [LW-1:0]         lc, rc, size_ext;
   logic                  lc_ok, rc_ok;
   logic [CW-1:0]         km1;
   logic                  pick_left, pick_right, moved;
   logic [DATA_WIDTH-1:0] cand, child_val;
   logic [AW-1:0]         child_idx;

   assign lc       = {1'b0, node_ff, 1'b1};
   assign rc       = lc + LW'(1);
   assign size_ext = LW'(size_ff);
   assign lc_ok    = lc < size_ext;
   assign rc_ok    = rc < size_ext;
   assign km1      = k_ff - CW'(1);

   // Pick the smallest of parent, left and right; ties keep the earlier one.
   assign pick_left  = $signed(lv_ff) < $signed(hold_ff);
   assign cand       = pick_left ? lv_ff : hold_ff;
   assign pick_right = rc_ok && ($signed(rd_data) < $signed(cand));
   assign moved      = pick_left || pick_right;
   assign child_val  = pick_right ? rd_data : lv_ff;
   assign child_idx  = pick_right ? rc[AW-1:0] : lc[AW-1:0];

   always_comb begin
      state_in   = state_ff;
      extract_in = extract_ff;
      done_in    = 1'b0;
      n_in       = n_ff;
      k_in       = k_ff;
      size_in    = size_ff;
      node_in    = node_ff;
      hold_in    = hold_ff;
      lv_in      = lv_ff;
      wr_en      = 1'b0;
      wr_addr    = node_ff;
      wr_data    = hold_ff;
      rd_addr    = '0;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               n_in       = count;
               k_in       = count >> 1;
               extract_in = 1'b0;
               state_in   = S_BLD_RD;
            end
         end
         S_BLD_RD: begin
            rd_addr  = km1[AW-1:0];
            node_in  = km1[AW-1:0];
            size_in  = n_ff;
            state_in = S_BLD_LD;
         end
         S_BLD_LD: begin
            hold_in  = rd_data;
            state_in = S_CHK;
         end
         S_EX_R0: begin
            rd_addr  = '0;
            state_in = S_EX_RK;
         end
         S_EX_RK: begin
            rd_addr  = k_ff[AW-1:0];
            lv_in    = rd_data;
            state_in = S_EX_WR;
         end
         S_EX_WR: begin
            // Move the root to the end of the heap, sift the old tail from the root.
            hold_in  = rd_data;
            wr_en    = 1'b1;
            wr_addr  = k_ff[AW-1:0];
            wr_data  = lv_ff;
            node_in  = '0;
            size_in  = k_ff;
            state_in = S_CHK;
         end
         S_RC: begin
            rd_addr  = rc_ok ? rc[AW-1:0] : lc[AW-1:0];
            lv_in    = rd_data;
            state_in = S_DEC;
         end
         S_CHK, S_DEC: begin
            if (state_ff == S_CHK && lc_ok) begin
               rd_addr  = lc[AW-1:0];
               state_in = S_RC;
            end else if (state_ff == S_DEC && moved) begin
               wr_en    = 1'b1;
               wr_data  = child_val;
               node_in  = child_idx;
               state_in = S_CHK;
            end else begin
               // Sift ends here: park the held value and pick the next heap step.
               wr_en = 1'b1;
               if (!extract_ff) begin
                  if (k_ff == CW'(1)) begin
                     extract_in = 1'b1;
                     k_in       = n_ff - CW'(1);
                     state_in   = S_EX_R0;
                  end else begin
                     k_in     = km1;
                     state_in = S_BLD_RD;
                  end
               end else begin
                  if (k_ff == CW'(1)) begin
                     done_in  = 1'b1;
                     state_in = S_IDLE;
                  end else begin
                     k_in     = km1;
                     state_in = S_EX_R0;
                  end
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         extract_ff <= 1'b0;
         done_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         extract_ff <= extract_in;
         done_ff    <= done_in;
      end
      n_ff    <= n_in;
      k_ff    <= k_in;
      size_ff <= size_in;
      node_ff <= node_in;
      hold_ff <= hold_in;
      lv_ff   <= lv_in;
   end

   assign stat.busy = (state_ff != S_IDLE) || done_ff;
   assign stat.done = done_ff;

endmodule

// ===== hw/rtl/heap_sort_engine_top.sv =====
// Heap sort engine. Load items (func = load) write one signed element each into
// a single-port-read, single-port-write memory of DEPTH entries; loads past
// DEPTH are dropped, but their last flag still closes the set. The item that
// carries last starts an in-place heap sort (min-heap build, then repeated
// root extraction), leaving the set in non-increasing order. While the sort
// runs no item is accepted. The sort is bound by the one memory read port:
// each heap level reads the left child, reads the right child, then compares
// and writes back; each build step first fetches its node, and each
// extraction first swaps the root with the tail. A fetch reads the memory
// (registered read) and yields one result item with the next element,
// marked final on the last one, or an empty result (value 0) when the
// set is not sorted or used up. A result that waits on the receiver holds
// off the next item. A load that follows a sorted set discards it and
// starts a new one. The memory needs no clearing: only entries of the
// current set are ever read.
module heap_sort_engine_top #(
   parameter int DEPTH      = 1024,
   parameter int DATA_WIDTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   hse_req_if.sink    req,
   hse_rsp_if.source  rsp
);
   import hse_pkg::*;

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   typedef enum logic [1:0] {ST_IDLE, ST_SORT, ST_FETCH} state_type;

   state_type             state_ff;
   logic                  sorted_ff;
   logic [CW-1:0]         count_ff;
   logic [CW-1:0]         rpos_ff;
   logic                  final_pend_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [DATA_WIDTH-1:0] rsp_value_ff;
   logic                  rsp_final_ff;
   logic                  rsp_empty_ff;

   logic                  accept;
   logic                  is_load, is_fetch;
   logic [CW-1:0]         base_count;
   logic                  room;
   logic [CW-1:0]         new_count;
   logic                  hit;
   logic                  sort_start;
   sort_stat_type         sort_stat;

   logic                  srt_wr_en;
   logic [AW-1:0]         srt_wr_addr;
   logic [DATA_WIDTH-1:0] srt_wr_data;
   logic [AW-1:0]         srt_rd_addr;

   logic                  mem_wr_en;
   logic [AW-1:0]         mem_wr_addr;
   logic [DATA_WIDTH-1:0] mem_wr_data;
   logic [AW-1:0]         mem_rd_addr;
   logic [DATA_WIDTH-1:0] mem_rd_data;

   // Accept only in idle, and only with the result register free or freeing.
   assign req.ready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp.ready);
   assign accept    = req.valid && req.ready;
   assign is_load   = accept && (req.func == FUNC_LOAD);
   assign is_fetch  = accept && (req.func == FUNC_FETCH);

   // A load after a sorted set starts over from an empty set.
   assign base_count = sorted_ff ? '0 : count_ff;
   assign room       = base_count < CW'(DEPTH);
   assign new_count  = room ? base_count + CW'(1) : base_count;
   assign hit        = sorted_ff && (rpos_ff < count_ff);
   assign sort_start = is_load && req.last && (new_count >= CW'(2));

   // Raise the result for a fetch that missed or whose read has landed; hold
   // it until taken.
   assign rsp_valid_in = (state_ff == ST_FETCH) || (is_fetch && !hit) ||
                         (rsp_valid_ff && !rsp.ready);

   // Memory ports: the sorter owns them while it runs.
   assign mem_wr_en   = sort_stat.busy ? srt_wr_en   : (is_load && room);
   assign mem_wr_addr = sort_stat.busy ? srt_wr_addr : base_count[AW-1:0];
   assign mem_wr_data = sort_stat.busy ? srt_wr_data : DATA_WIDTH'(req.value);
   assign mem_rd_addr = sort_stat.busy ? srt_rd_addr : rpos_ff[AW-1:0];

   hse_mem #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH),
      .AW         (AW)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   hse_sorter #(
      .DATA_WIDTH (DATA_WIDTH),
      .AW         (AW),
      .CW         (CW)
   ) u_sorter (
      .clock   (clock),
      .reset   (reset),
      .start   (sort_start),
      .count   (new_count),
      .stat    (sort_stat),
      .wr_en   (srt_wr_en),
      .wr_addr (srt_wr_addr),
      .wr_data (srt_wr_data),
      .rd_addr (srt_rd_addr),
      .rd_data (mem_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sorted_ff    <= 1'b0;
         count_ff     <= '0;
         rpos_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         case (state_ff)
            ST_IDLE: begin
               if (is_load) begin
                  count_ff <= new_count;
                  rpos_ff  <= '0;
                  if (req.last && !sort_start) begin
                     sorted_ff <= 1'b1;
                  end else if (sort_start) begin
                     sorted_ff <= 1'b0;
                     state_ff  <= ST_SORT;
                  end else begin
                     sorted_ff <= 1'b0;
                  end
               end else if (is_fetch) begin
                  if (hit) begin
                     // Read issued this cycle; data lands next cycle.
                     rpos_ff  <= rpos_ff + CW'(1);
                     state_ff <= ST_FETCH;
                  end
               end
            end
            ST_FETCH: begin
               state_ff <= ST_IDLE;
            end
            ST_SORT: begin
               if (sort_stat.done) begin
                  sorted_ff <= 1'b1;
                  rpos_ff   <= '0;
                  state_ff  <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
      // Result payload.
      if (state_ff == ST_IDLE && is_fetch) begin
         final_pend_ff <= (rpos_ff + CW'(1)) == count_ff;
         if (!hit) begin
            rsp_value_ff <= '0;
            rsp_final_ff <= 1'b0;
            rsp_empty_ff <= 1'b1;
         end
      end
      if (state_ff == ST_FETCH) begin
         rsp_value_ff <= mem_rd_data;
         rsp_final_ff <= final_pend_ff;
         rsp_empty_ff <= 1'b0;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.sorted_value = rsp_value_ff;
   assign rsp.final_res    = rsp_final_ff;
   assign rsp.empty_res    = rsp_empty_ff;

   // No item is taken while the sorter holds the memory.
   a_no_accept_in_sort: assert property (@(posedge clock) disable iff (reset)
      sort_stat.busy |-> !req.ready)
      else $error("item accepted while sort runs");

   // Read position never runs past the element count.
   a_rpos_bound: assert property (@(posedge clock) disable iff (reset)
      (rpos_ff <= count_ff) && (count_ff <= CW'(DEPTH)))
      else $error("read position or count out of range");

   // An empty result carries a zero value and no final mark.
   a_empty_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_empty_ff) |-> (rsp_value_ff == '0 && !rsp_final_ff))
      else $error("empty result carries data");

   // A fetch that hits raises a non-empty result after its read lands.
   a_fetch_latency: assert property (@(posedge clock) disable iff (reset)
      (is_fetch && hit) |=> ##1 rsp_valid_ff && !rsp_empty_ff)
      else $error("fetch result missing");

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import hse_pkg::*;

   localparam int DEPTH        = 1024;
   localparam int DATA_WIDTH   = 32;
   // Random-set items, split over three phases; the overfilled set comes on top.
   localparam int RANDOM_ITEMS = 150;
   localparam int FULL_FETCHES = 16;
   // Watch for stray results after the last expected answer; leave ample room.
   localparam int DRAIN_CYCLES = 100;
   // Far beyond the slowest correct run, which includes one full-depth sort.
   localparam int RUN_LIMIT_NS = 2_000_000;

   localparam logic signed [DATA_WIDTH-1:0] VALUE_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic signed [DATA_WIDTH-1:0] VALUE_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   // How the elements of one set are spread over the value range.
   typedef enum int {
      SPREAD_FULL,
      SPREAD_NARROW,
      SPREAD_EDGES
   } spread_type;

   // Predicts what each fetch returns and holds those answers until they come.
   class sorted_set_board_type;
      typedef struct {
         logic signed [DATA_WIDTH-1:0] sorted_value;
         logic                         final_res;
         logic                         empty_res;
      } fetch_answer_type;

      logic signed [DATA_WIDTH-1:0] elems [DEPTH];
      int unsigned                  count;
      int unsigned                  rd_pos;
      bit                           sorted;
      fetch_answer_type             answer_q[$];
      int                           errors;

      function new();
         count  = 0;
         rd_pos = 0;
         sorted = 0;
         errors = 0;
      endfunction

      // Min-heap sift: push node down until both children are not smaller.
      function void sift_down(int unsigned size, int unsigned node);
         int unsigned                  pick;
         int unsigned                  lc;
         int unsigned                  rc;
         logic signed [DATA_WIDTH-1:0] held;
         bit                           settled;
         settled = 0;
         while (!settled) begin
            pick = node;
            lc   = 2 * node + 1;
            rc   = 2 * node + 2;
            if (lc < size && elems[lc] < elems[pick]) pick = lc;
            if (rc < size && elems[rc] < elems[pick]) pick = rc;
            if (pick == node) begin
               settled = 1;
            end else begin
               held        = elems[node];
               elems[node] = elems[pick];
               elems[pick] = held;
               node        = pick;
            end
         end
      endfunction

      // Build the min-heap, then move the minimum to the tail each round.
      function void heap_sort();
         int unsigned                  k;
         logic signed [DATA_WIDTH-1:0] held;
         if (count < 2) return;
         for (k = count / 2; k > 0; k--) sift_down(count, k - 1);
         for (k = count - 1; k > 0; k--) begin
            held     = elems[0];
            elems[0] = elems[k];
            elems[k] = held;
            sift_down(k, 0);
         end
      endfunction

      function void note_request(logic func, logic signed [DATA_WIDTH-1:0] value,
                                 logic last);
         fetch_answer_type ans;
         if (func == FUNC_LOAD) begin
            if (sorted) begin
               count  = 0;
               rd_pos = 0;
               sorted = 0;
            end
            if (count < DEPTH) begin
               elems[count] = value;
               count++;
            end
            if (last) begin
               heap_sort();
               rd_pos = 0;
               sorted = 1;
            end
         end else begin
            if (sorted && rd_pos < count) begin
               ans.sorted_value = elems[rd_pos];
               ans.final_res    = (rd_pos + 1 == count);
               ans.empty_res    = 1'b0;
               rd_pos++;
            end else begin
               ans.sorted_value = '0;
               ans.final_res    = 1'b0;
               ans.empty_res    = 1'b1;
            end
            answer_q.push_back(ans);
         end
      endfunction

      function void check_result(logic signed [DATA_WIDTH-1:0] sorted_value,
                                 logic final_res, logic empty_res);
         fetch_answer_type ans;
         if (answer_q.size() == 0) begin
            $display("%0t: result with none pending: value %0d final %0b empty %0b",
                     $time, sorted_value, final_res, empty_res);
            errors++;
            return;
         end
         ans = answer_q.pop_front();
         if (sorted_value !== ans.sorted_value) begin
            $display("%0t: sorted_value expected %0d actual %0d",
                     $time, ans.sorted_value, sorted_value);
            errors++;
         end
         if (final_res !== ans.final_res) begin
            $display("%0t: final_res expected %0b actual %0b",
                     $time, ans.final_res, final_res);
            errors++;
         end
         if (empty_res !== ans.empty_res) begin
            $display("%0t: empty_res expected %0b actual %0b",
                     $time, ans.empty_res, empty_res);
            errors++;
         end
      endfunction

      function int pending();
         return answer_q.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;

   hse_req_if #(.DATA_WIDTH(DATA_WIDTH)) req_ch ();
   hse_rsp_if #(.DATA_WIDTH(DATA_WIDTH)) rsp_ch ();

   heap_sort_engine_top #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) DUT (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   sorted_set_board_type board;
   int                   send_idle_pct = 20;
   int                   rcv_idle_pct  = 57;
   int                   items_sent    = 0;

   // 2 ns period: one delay high, one low.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Stop a hung run; the normal end comes long before this.
   initial begin
      #(RUN_LIMIT_NS);
      $display("end of test: mismatches");
      $finish;
   end

   // Result side: sample the handshake as it stood at the edge, then pick the
   // next ready level. Outputs are read before any update of this edge lands.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         board.check_result(rsp_ch.sorted_value, rsp_ch.final_res, rsp_ch.empty_res);
      end
      rsp_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
   end

   // Offer one item and hold it until the block takes it. Valid drops only
   // inside an idle gap, so a back-to-back item never sees valid pulse low.
   task automatic send_item(logic func, logic signed [DATA_WIDTH-1:0] value, logic last);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.func  <= func;
      req_ch.value <= value;
      req_ch.last  <= last;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      board.note_request(func, value, last);
      items_sent++;
   endtask

   // Value and last mean nothing on a fetch; toggle them anyway.
   task automatic send_fetch();
      send_item(FUNC_FETCH, DATA_WIDTH'($urandom), 1'($urandom_range(1)));
   endtask

   function automatic logic signed [DATA_WIDTH-1:0] pick_value(spread_type spread);
      logic signed [DATA_WIDTH-1:0] v;
      // Sprinkle boundary values into every set now and then.
      if (spread == SPREAD_EDGES || $urandom_range(9) == 0) begin
         case ($urandom_range(4))
            0:       v = VALUE_MAX;
            1:       v = VALUE_MIN;
            2:       v = '0;
            3:       v = '1;
            default: v = 1;
         endcase
      end else if (spread == SPREAD_NARROW) begin
         // Tight range: plenty of equal elements.
         v = $signed($urandom_range(6)) - 3;
      end else begin
         v = $urandom;
      end
      return v;
   endfunction

   // Load a set of n elements, last on the final one. Stray fetches mixed in
   // hit either the old set (before the first load) or an unsorted set.
   task automatic load_set(int unsigned n, spread_type spread, int unsigned stray_pct);
      for (int unsigned i = 0; i < n; i++) begin
         if ($urandom_range(99) < stray_pct) send_fetch();
         send_item(FUNC_LOAD, pick_value(spread), i == n - 1);
      end
   endtask

   task automatic fetch_run(int unsigned m);
      for (int unsigned i = 0; i < m; i++) send_fetch();
   endtask

   // One set with random content. Mostly read it out whole plus a few empty
   // fetches; sometimes abandon it partway or never read it at all.
   task automatic random_set();
      int unsigned n;
      int unsigned m;
      int unsigned roll;
      spread_type  spread;
      roll   = $urandom_range(99);
      n      = (roll < 85) ? $urandom_range(1, 24) : $urandom_range(25, 100);
      spread = spread_type'($urandom_range(2));
      load_set(n, spread, 8);
      roll = $urandom_range(99);
      if (roll < 70)      m = n + $urandom_range(0, 2);
      else if (roll < 90) m = $urandom_range(0, n);
      else                m = 0;
      fetch_run(m);
   endtask

   initial begin
      int phase_end;
      board = new();

      // Drive the request side to a known level before the first edge.
      reset        <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.func  <= FUNC_LOAD;
      req_ch.value <= '0;
      req_ch.last  <= 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: fetch with nothing loaded must answer empty.
      send_fetch();
      // Boundary values with a duplicate; read past the end twice.
      send_item(FUNC_LOAD, VALUE_MAX, 1'b0);
      send_item(FUNC_LOAD, VALUE_MIN, 1'b0);
      send_item(FUNC_LOAD, '0, 1'b0);
      send_item(FUNC_LOAD, '1, 1'b0);
      send_item(FUNC_LOAD, VALUE_MAX, 1'b0);
      send_item(FUNC_LOAD, 1, 1'b1);
      fetch_run(8);
      // Single-element set: its one fetch is final.
      send_item(FUNC_LOAD, 32'h5A5A_A5A5, 1'b1);
      send_fetch();
      // Fetch in the middle of loading, then leave the sorted set partly read.
      send_item(FUNC_LOAD, 32'h0000_7FFF, 1'b0);
      send_item(FUNC_LOAD, 32'hFFFF_8000, 1'b0);
      send_fetch();
      send_item(FUNC_LOAD, 32'h1234_5678, 1'b1);
      send_fetch();

      // Random, first idling mix.
      phase_end = items_sent + RANDOM_ITEMS / 3;
      while (items_sent < phase_end) random_set();

      // Swap the idling of the two sides.
      send_idle_pct = 57;
      rcv_idle_pct  = 20;
      phase_end = items_sent + RANDOM_ITEMS / 3;
      while (items_sent < phase_end) random_set();

      // No idling. Overfill the store once: the extra loads are dropped, but
      // the last flag on a dropped load still sorts the full set. Read the
      // front of it, then abandon it.
      send_idle_pct = 0;
      rcv_idle_pct  = 0;
      load_set(DEPTH + 3, SPREAD_FULL, 0);
      fetch_run(FULL_FETCHES);
      phase_end = items_sent + RANDOM_ITEMS / 3;
      while (items_sent < phase_end) random_set();
      req_ch.valid <= 1'b0;

      // Drain: wait for every answer, then watch for strays.
      while (board.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (board.errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
